// ----- rtl/lifo_stack_keyed_extract_core_assert.svh -----
// Assertion macros shared by the stack core and its checks.
`ifndef LIFO_STACK_KEYED_EXTRACT_CORE_ASSERT_SVH
`define LIFO_STACK_KEYED_EXTRACT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LSKE_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("lske assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LSKE_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("lske assertion failed");

`endif

// ----- rtl/lske_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the stack core.
package lske_pkg;

   localparam int DEPTH        = 32;
   localparam int KEY_BITS     = 16;
   localparam int PAYLOAD_BITS = 64;
   localparam int OPCODE_W     = 2;
   localparam int STATUS_W     = 3;
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int CNT_W        = $clog2(DEPTH + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH    = 2'd0,
      OP_EXTRACT = 2'd1,
      OP_DUMP    = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_PUSHED    = 3'd0,
      RSP_FULL      = 3'd1,
      RSP_EXTRACTED = 3'd2,
      RSP_NOT_FOUND = 3'd3,
      RSP_DUMP      = 3'd4,
      RSP_EMPTY     = 3'd5
   } rsp_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_DUMP
   } ctrl_state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           accept;
      logic           push_wr;
      logic           search_init;
      logic           dump_init;
      logic           shift_init;
      logic           shift_wr;
      logic           rd_en;
      logic           rd_up;
      logic           emit;
      rsp_status_type emit_status;
      logic           emit_data;
      logic           emit_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic match;
      logic scan_done;
      logic rd_vld;
      logic rd_last;
   } stat_type;

endpackage

// ----- rtl/lske_ctrl.sv -----
// Controller state machine that sequences push, keyed extract and dump transactions.
module lske_ctrl import lske_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  stat_type            stat,
   output logic                busy,
   output cmd_type             cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   opcode_type     op;

   assign op   = opcode_type'(req_opcode);
   assign busy = (state_ff != ST_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (op)
                  OP_EXTRACT: state_in = ST_SEARCH;
                  OP_DUMP: begin
                     if (!stat.empty) begin
                        state_in = ST_DUMP;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (stat.match) begin
               state_in = ST_SHIFT;
            end else if (stat.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            if (stat.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (stat.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd             = '0;
      cmd.emit_status = RSP_PUSHED;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               case (op)
                  OP_PUSH: begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.push_wr     = !stat.full;
                     cmd.emit_status = stat.full ? RSP_FULL : RSP_PUSHED;
                  end
                  OP_EXTRACT: begin
                     cmd.search_init = 1'b1;
                  end
                  OP_DUMP: begin
                     if (stat.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_last   = 1'b1;
                        cmd.emit_status = RSP_EMPTY;
                     end else begin
                        cmd.dump_init = 1'b1;
                     end
                  end
                  default: cmd.accept = 1'b1;
               endcase
            end
         end
         ST_SEARCH: begin
            if (stat.match) begin
               cmd.emit        = 1'b1;
               cmd.emit_data   = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = RSP_EXTRACTED;
               cmd.shift_init  = 1'b1;
            end else if (stat.scan_done) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = RSP_NOT_FOUND;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         ST_SHIFT: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_up    = 1'b1;
            cmd.shift_wr = 1'b1;
         end
         ST_DUMP: begin
            cmd.rd_en       = 1'b1;
            cmd.rd_up       = 1'b1;
            cmd.emit        = stat.rd_vld;
            cmd.emit_data   = 1'b1;
            cmd.emit_last   = stat.rd_last;
            cmd.emit_status = RSP_DUMP;
         end
         default: cmd.accept = 1'b0;
      endcase
   end

endmodule

// ----- rtl/lske_dpath.sv -----
// Datapath of the stack core: entry memory, count, scan pointers and result registers.
module lske_dpath import lske_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  logic [KEY_BITS-1:0]     req_key,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   output stat_type                stat,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [KEY_BITS-1:0]     rsp_entry_key,
   output logic [PAYLOAD_BITS-1:0] rsp_entry_payload,
   output logic                    rsp_last
);

   entry_type mem [DEPTH];

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        count_m1;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic [KEY_BITS-1:0]     key_ff;
   entry_type               rd_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    rd_vld_ff;
   logic                    rd_go;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   entry_type               wr_data;
   logic                    rsp_valid_ff;
   rsp_status_type          rsp_status_ff;
   logic [KEY_BITS-1:0]     rsp_key_ff;
   logic [PAYLOAD_BITS-1:0] rsp_payload_ff;
   logic                    rsp_last_ff;

   assign count_m1 = count_ff - CNT_W'(1);
   assign rd_go    = cmd.rd_en && (left_ff != '0);

   // Entry count and scan pointer updates.
   always_comb begin
      count_in = count_ff;
      if (cmd.push_wr) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.shift_init) begin
         count_in = count_m1;
      end
   end

   always_comb begin
      ptr_in  = ptr_ff;
      left_in = left_ff;
      if (cmd.search_init) begin
         ptr_in  = count_m1[IDX_W-1:0];
         left_in = count_ff;
      end else if (cmd.dump_init) begin
         ptr_in  = '0;
         left_in = count_ff;
      end else if (cmd.shift_init) begin
         // Entries above the removed one each move down by one slot.
         ptr_in  = rd_idx_ff + IDX_W'(1);
         left_in = count_m1 - CNT_W'(rd_idx_ff);
      end else if (rd_go) begin
         ptr_in  = cmd.rd_up ? (ptr_ff + IDX_W'(1)) : (ptr_ff - IDX_W'(1));
         left_in = left_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         left_ff   <= '0;
         ptr_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         left_ff   <= left_in;
         ptr_ff    <= ptr_in;
         rd_vld_ff <= rd_go;
      end
   end

   // Search key is held for the whole transaction.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff <= req_key;
      end
   end

   // Memory write port: push on top, or move a read entry down one slot.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = entry_type'{key: req_key, payload: req_payload};
      if (cmd.push_wr) begin
         wr_en = 1'b1;
      end else if (cmd.shift_wr && rd_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff - IDX_W'(1);
         wr_data = rd_ff;
      end
   end

   // Entry memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_go) begin
         rd_ff     <= mem[ptr_ff];
         rd_idx_ff <= ptr_ff;
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.full      = (count_ff == CNT_W'(DEPTH));
      stat.empty     = (count_ff == '0);
      stat.match     = rd_vld_ff && (rd_ff.key == key_ff);
      stat.scan_done = (left_ff == '0) && !rd_vld_ff;
      stat.rd_vld    = rd_vld_ff;
      stat.rd_last   = (CNT_W'(rd_idx_ff) == count_m1);
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= cmd.emit_status;
      rsp_key_ff     <= cmd.emit_data ? rd_ff.key : '0;
      rsp_payload_ff <= cmd.emit_data ? rd_ff.payload : '0;
      rsp_last_ff    <= cmd.emit_last;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_key     = rsp_key_ff;
   assign rsp_entry_payload = rsp_payload_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ----- rtl/lifo_stack_keyed_extract_core.sv -----
// Top level of the keyed-extract LIFO; every result is on the ports the cycle after it is made.
// A push is accepted with busy low and its result follows in the next cycle, one push per cycle.
// Extract scans one entry per cycle from the top, then moves the entries above the hit down one
// slot per cycle; busy stays high through the scan and the move, or through the scan on a miss.
// Dump streams one entry per cycle from the bottom with busy high; the single memory read port
// sets this pace. The receiver cannot stall; synchronous reset empties the store.
`include "lifo_stack_keyed_extract_core_assert.svh"

module lifo_stack_keyed_extract_core import lske_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [OPCODE_W-1:0]     req_opcode,
   input  logic [KEY_BITS-1:0]     req_key,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [KEY_BITS-1:0]     rsp_entry_key,
   output logic [PAYLOAD_BITS-1:0] rsp_entry_payload,
   output logic                    rsp_last
);

   cmd_type  cmd;
   stat_type stat;
   logic     rsp_more;
   logic     rsp_no_entry;
   logic     rsp_zero;
   logic     rsp_extracted;
   logic     extract_take;
   logic     search_hit;

   // Controller.
   lske_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .busy       (busy),
      .cmd        (cmd)
   );

   // Datapath.
   lske_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_entry_key     (rsp_entry_key),
      .rsp_entry_payload (rsp_entry_payload),
      .rsp_last          (rsp_last)
   );

   // Conditions used by the checks below.
   assign rsp_more      = rsp_valid && !rsp_last;
   assign rsp_no_entry  = rsp_valid && (rsp_status != RSP_DUMP) && (rsp_status != RSP_EXTRACTED);
   assign rsp_zero      = (rsp_entry_key == '0) && (rsp_entry_payload == '0);
   assign rsp_extracted = rsp_valid && rsp_last && (rsp_status == RSP_EXTRACTED);
   assign extract_take  = start && !busy && (req_opcode == OP_EXTRACT);
   // Only the search phase reads downward, so a key compare there is a real hit.
   assign search_hit    = stat.match && busy && !cmd.rd_up;

   // A dump streams its entries on consecutive cycles until the last one.
   `LSKE_ASSERT_NEXT(a_dump_stream, clock, reset, rsp_more, rsp_valid && (rsp_status == RSP_DUMP))

   // An accepted extract always keeps the core busy for the scan.
   `LSKE_ASSERT_NEXT(a_extract_busy, clock, reset, extract_take, busy)

   // Results without an entry carry zero key and payload.
   `LSKE_ASSERT_NOW(a_zero_fields, clock, reset, rsp_no_entry, rsp_zero)

   // A key hit ends the scan with exactly one extracted result.
   `LSKE_ASSERT_NEXT(a_hit_emits, clock, reset, search_hit, rsp_extracted)

endmodule

// ----- tb/sv/lifo_stack_keyed_extract_core_tb.sv -----
// Self-checking testbench for the keyed-extract LIFO core: directed and random transactions.
module lifo_stack_keyed_extract_core_tb import lske_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 10;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      rsp_status_type          status;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
      logic                    last;
   } stack_result_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [OPCODE_W-1:0]     req_opcode;
   logic [KEY_BITS-1:0]     req_key;
   logic [PAYLOAD_BITS-1:0] req_payload;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic [KEY_BITS-1:0]     rsp_entry_key;
   logic [PAYLOAD_BITS-1:0] rsp_entry_payload;
   logic                    rsp_last;

   // Shadow copy of the stack, slot 0 at the bottom, and the results still owed by the core.
   entry_type        shadow_stack[$];
   stack_result_type owed_results[$];
   stack_result_type oldest_owed;
   int               error_count;
   int               quiet_cycles;
   bit               gaps_on;

   lifo_stack_keyed_extract_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_entry_key     (rsp_entry_key),
      .rsp_entry_payload (rsp_entry_payload),
      .rsp_last          (rsp_last)
   );

   // Free-running clock.
   always begin
      clock = 1'b1;
      #CLK_HALF;
      clock = 1'b0;
      #CLK_HALF;
   end

   // Queue one expected result.
   function automatic void owe_result(rsp_status_type status, logic [KEY_BITS-1:0] key,
                                      logic [PAYLOAD_BITS-1:0] payload, logic last);
      stack_result_type r;
      r.status  = status;
      r.key     = key;
      r.payload = payload;
      r.last    = last;
      owed_results.push_back(r);
   endfunction

   // Apply one accepted transaction to the shadow stack and record what it must produce.
   function automatic void apply_stack_op(logic [OPCODE_W-1:0] op, logic [KEY_BITS-1:0] key,
                                          logic [PAYLOAD_BITS-1:0] payload);
      entry_type e;
      int        hit;
      hit = -1;
      case (op)
         OP_PUSH: begin
            if (shadow_stack.size() >= DEPTH) begin
               owe_result(RSP_FULL, '0, '0, 1'b1);
            end else begin
               e.key     = key;
               e.payload = payload;
               shadow_stack.push_back(e);
               owe_result(RSP_PUSHED, '0, '0, 1'b1);
            end
         end
         OP_EXTRACT: begin
            // The topmost match wins; the entries above it slide down by one.
            for (int i = shadow_stack.size() - 1; i >= 0 && hit < 0; i--) begin
               if (shadow_stack[i].key == key) hit = i;
            end
            if (hit < 0) begin
               owe_result(RSP_NOT_FOUND, '0, '0, 1'b1);
            end else begin
               e = shadow_stack[hit];
               shadow_stack.delete(hit);
               owe_result(RSP_EXTRACTED, e.key, e.payload, 1'b1);
            end
         end
         OP_DUMP: begin
            if (shadow_stack.size() == 0) begin
               owe_result(RSP_EMPTY, '0, '0, 1'b1);
            end else begin
               foreach (shadow_stack[i])
                  owe_result(RSP_DUMP, shadow_stack[i].key, shadow_stack[i].payload,
                             i == shadow_stack.size() - 1);
            end
         end
         default: begin
            // The unused opcode leaves the store alone and produces nothing.
         end
      endcase
   endfunction

   // Present one transaction and hold it until the core takes it.
   task automatic issue_op(logic [OPCODE_W-1:0] op, logic [KEY_BITS-1:0] key,
                           logic [PAYLOAD_BITS-1:0] payload);
      @(negedge clock);
      start       <= 1'b1;
      req_opcode  <= op;
      req_key     <= key;
      req_payload <= payload;
      do @(posedge clock); while (busy);
      apply_stack_op(op, key, payload);
   endtask

   // Drop start for a short burst of idle cycles.
   task automatic hold_off(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic maybe_gap();
      if (gaps_on && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 4));
   endtask

   // Keys mostly come from a small pool so that duplicates are common.
   function automatic logic [KEY_BITS-1:0] random_key();
      if ($urandom_range(0, 3) == 0) return KEY_BITS'($urandom());
      return KEY_BITS'($urandom_range(0, 15));
   endfunction

   function automatic logic [PAYLOAD_BITS-1:0] random_payload();
      return {$urandom(), $urandom()};
   endfunction

   // Extract keys usually hit a stored entry; the rest are likely misses.
   function automatic logic [KEY_BITS-1:0] search_key();
      if (shadow_stack.size() > 0 && $urandom_range(0, 9) < 7)
         return shadow_stack[$urandom_range(0, shadow_stack.size() - 1)].key;
      return random_key();
   endfunction

   // Compare one field of a result with its expectation.
   task automatic check_field(string name, logic [PAYLOAD_BITS-1:0] expected,
                              logic [PAYLOAD_BITS-1:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
         error_count++;
      end
   endtask

   // Every result strobe is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d key %h payload %h",
                     $time, rsp_status, rsp_entry_key, rsp_entry_payload);
            error_count++;
         end else begin
            oldest_owed = owed_results.pop_front();
            check_field("status", oldest_owed.status, rsp_status);
            check_field("entry_key", oldest_owed.key, rsp_entry_key);
            check_field("entry_payload", oldest_owed.payload, rsp_entry_payload);
            check_field("last", oldest_owed.last, rsp_last);
         end
      end
   end

   // Watchdog: too long without any transaction or result ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Empty-store cases, extreme fields, duplicate keys and the unused opcode.
   task automatic test_directed();
      issue_op(OP_EXTRACT, 16'h1234, '1);
      issue_op(OP_DUMP, '0, '0);
      issue_op(OP_UNUSED, '1, '1);
      issue_op(OP_PUSH, 16'h0000, 64'h0);
      issue_op(OP_PUSH, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      issue_op(OP_PUSH, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA);
      issue_op(OP_PUSH, 16'hAAAA, 64'h5555_5555_5555_5555);
      issue_op(OP_PUSH, 16'hFFFF, 64'h0123_4567_89AB_CDEF);
      issue_op(OP_DUMP, '0, '0);
      // The later of two equal keys comes out first.
      issue_op(OP_EXTRACT, 16'hFFFF, '0);
      issue_op(OP_EXTRACT, 16'h5555, '1);
      issue_op(OP_EXTRACT, 16'h7777, '0);
      issue_op(OP_UNUSED, 16'h0F0F, 64'h0F0F_0F0F_0F0F_0F0F);
      issue_op(OP_DUMP, '0, '0);
      issue_op(OP_EXTRACT, 16'h0000, '0);
      issue_op(OP_EXTRACT, 16'hAAAA, '0);
      issue_op(OP_EXTRACT, 16'hFFFF, '0);
      issue_op(OP_EXTRACT, 16'hFFFF, '0);
      issue_op(OP_DUMP, '0, '0);
   endtask

   // Fill the store past full, dump it whole, then drain it by key.
   task automatic test_fill_and_drain(int rounds);
      for (int r = 0; r < rounds; r++) begin
         while (shadow_stack.size() < DEPTH) begin
            issue_op(OP_PUSH, random_key(), random_payload());
            maybe_gap();
         end
         repeat ($urandom_range(1, 3)) begin
            issue_op(OP_PUSH, random_key(), random_payload());
            maybe_gap();
         end
         issue_op(OP_DUMP, random_key(), random_payload());
         while (shadow_stack.size() > 0) begin
            issue_op(OP_EXTRACT, search_key(), random_payload());
            maybe_gap();
         end
         issue_op(OP_EXTRACT, random_key(), random_payload());
         issue_op(OP_DUMP, random_key(), random_payload());
      end
   endtask

   // Random mix of all opcodes, with noise now and then.
   task automatic test_mixed_traffic(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            issue_op(OP_PUSH, random_key(), random_payload());
         else if (pick < 82)
            issue_op(OP_EXTRACT, search_key(), random_payload());
         else if (pick < 95)
            issue_op(OP_DUMP, random_key(), random_payload());
         else
            issue_op(OP_UNUSED, random_key(), random_payload());
         maybe_gap();
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_opcode  = '0;
      req_key     = '0;
      req_payload = '0;
      error_count = 0;
      quiet_cycles = 0;
      gaps_on     = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_fill_and_drain(2);
      test_mixed_traffic(200);
      // Back-to-back transactions to close the run.
      gaps_on = 1'b0;
      test_mixed_traffic(100);

      @(negedge clock);
      start <= 1'b0;
      wait (owed_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lske_pkg.sv
rtl/lske_ctrl.sv
rtl/lske_dpath.sv
rtl/lifo_stack_keyed_extract_core.sv
tb/sv/lifo_stack_keyed_extract_core_tb.sv
